/* rtl/mpc_pkg.sv */
// Package for the moisture pump controller: mode codes, register indexes,
// field widths and register reset values. No dependencies.
package mpc_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int MOIST_W = 8;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WATER = 2'd1;
    localparam logic [1:0] MODE_SOAK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DRY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOAK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd4;

    localparam logic [MOIST_W-1:0] DRY_RESET      = 8'd30;
    localparam logic [MOIST_W-1:0] WET_RESET      = 8'd60;
    localparam logic [LIMIT_W-1:0] WATER_RESET    = 16'd3000;
    localparam logic [LIMIT_W-1:0] SOAK_RESET     = 16'd5000;
    localparam logic [LIMIT_W-1:0] COOLDOWN_RESET = 16'd2000;
    localparam logic [MOIST_W-1:0] MOIST_RESET    = 8'd50;

endpackage

/* rtl/moisture_pump_controller.sv */
// Moisture pump controller top level: input word register, one tick of
// controller logic, result word register. Depends on mpc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one timer tick per word:
//   sample_valid, moisture, button_press. Output channel (out_valid /
//   out_stall) returns one result word per tick: pump_on, mode,
//   last_moisture, press_accepted. The receiver of each channel drives
//   stall; a word moves on an edge with valid high and stall low.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   dry_threshold, wet_threshold, water_limit_ticks, soak_ticks and
//   cooldown_ticks at indexes 0..4; cfg_ready is always high, other
//   indexes are dropped. Write only while no tick is in flight.
//   Path: an accepted tick enters the input word register, then the result
//   word register. Throughput: one tick per cycle while out_stall is low;
//   the controller state updates in the same edge that loads the result register.
//   Stall: when the result register is held, the input register holds too
//   and in_stall rises; nothing is dropped or repeated.
//   Reset: registers return to their defaults, mode idle, held moisture 50,
//   both timers zero (so the button cooldown runs from reset), no words.
module moisture_pump_controller
    import mpc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input tick channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  sample_valid,
    input  logic [MOIST_W-1:0]    moisture,
    input  logic                  button_press,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pump_on,
    output logic [1:0]            mode,
    output logic [MOIST_W-1:0]    last_moisture,
    output logic                  press_accepted,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Comparisons run at the wider of timer and limit width.
    localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration registers
    logic [MOIST_W-1:0] dry_reg;
    logic [MOIST_W-1:0] wet_reg;
    logic [LIMIT_W-1:0] water_lim_reg;
    logic [LIMIT_W-1:0] soak_lim_reg;
    logic [LIMIT_W-1:0] cooldown_reg;

    // Controller state
    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [MOIST_W-1:0]    held_reg;
    logic [MOIST_W-1:0]    held_next;
    logic [TIMER_BITS-1:0] phase_reg;
    logic [TIMER_BITS-1:0] phase_next;
    logic [TIMER_BITS-1:0] age_reg;
    logic [TIMER_BITS-1:0] age_next;

    // Input word register
    logic               in_vld_reg;
    logic               in_sv_reg;
    logic [MOIST_W-1:0] in_moist_reg;
    logic               in_press_reg;

    // Result word register
    logic               out_vld_reg;
    logic               pump_reg;
    logic [1:0]         omode_reg;
    logic [MOIST_W-1:0] omoist_reg;
    logic               oacc_reg;

    logic advance;
    logic load_in;
    logic accept_press;
    logic [TIMER_BITS-1:0] age_inc;
    logic [TIMER_BITS-1:0] phase_inc;
    logic [TIMER_BITS-1:0] phase_mid;
    logic [1:0]            mode_mid;

    // Advance the input word whenever the result slot is free or draining.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign load_in  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // One tick of the controller, from the input word and current state.
    always_comb
    begin
        age_inc   = (age_reg == TIMER_MAX) ? age_reg : age_reg + 1'b1;
        phase_inc = phase_reg;
        if (mode_reg == MODE_WATER || mode_reg == MODE_SOAK)
        begin
            phase_inc = (phase_reg == TIMER_MAX) ? phase_reg : phase_reg + 1'b1;
        end

        accept_press = in_press_reg &&
            (CMP_W'(age_inc) >= CMP_W'(cooldown_reg));
        age_next  = accept_press ? '0 : age_inc;
        mode_mid  = mode_reg;
        phase_mid = phase_inc;
        if (accept_press && mode_reg == MODE_IDLE)
        begin
            mode_mid  = MODE_WATER;
            phase_mid = '0;
        end

        held_next  = in_sv_reg ? in_moist_reg : held_reg;
        mode_next  = mode_mid;
        phase_next = phase_mid;

        unique case (mode_mid)
            MODE_IDLE:
            begin
                if (held_next < dry_reg)
                begin
                    mode_next  = MODE_WATER;
                    phase_next = '0;
                end
            end
            MODE_WATER:
            begin
                if (held_next >= wet_reg ||
                    CMP_W'(phase_mid) >= CMP_W'(water_lim_reg))
                begin
                    mode_next  = MODE_SOAK;
                    phase_next = '0;
                end
            end
            MODE_SOAK:
            begin
                if (CMP_W'(phase_mid) >= CMP_W'(soak_lim_reg))
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg       <= DRY_RESET;
            wet_reg       <= WET_RESET;
            water_lim_reg <= WATER_RESET;
            soak_lim_reg  <= SOAK_RESET;
            cooldown_reg  <= COOLDOWN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DRY:      dry_reg       <= cfg_data[MOIST_W-1:0];
                REG_WET:      wet_reg       <= cfg_data[MOIST_W-1:0];
                REG_WATER:    water_lim_reg <= cfg_data[LIMIT_W-1:0];
                REG_SOAK:     soak_lim_reg  <= cfg_data[LIMIT_W-1:0];
                REG_COOLDOWN: cooldown_reg  <= cfg_data[LIMIT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Controller state moves with the word that enters the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            held_reg  <= MOIST_RESET;
            phase_reg <= '0;
            age_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
            age_reg   <= age_next;
        end
    end

    // Input word register: load on accept, drop once advanced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (load_in)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_sv_reg    <= sample_valid;
            in_moist_reg <= moisture;
            in_press_reg <= button_press;
        end
    end

    // Result word register: hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pump_reg   <= (mode_next == MODE_WATER);
            omode_reg  <= mode_next;
            omoist_reg <= held_next;
            oacc_reg   <= accept_press;
        end
    end

    assign out_valid      = out_vld_reg;
    assign pump_on        = pump_reg;
    assign mode           = omode_reg;
    assign last_moisture  = omoist_reg;
    assign press_accepted = oacc_reg;

    // The shown result always matches the state it left behind.
    a_mode_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (omode_reg == mode_reg && omoist_reg == held_reg))
        else $error("result mode or moisture differs from controller state");

    a_pump_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (pump_reg == (omode_reg == MODE_WATER)))
        else $error("pump drive disagrees with mode");

    a_press_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && oacc_reg) |-> (age_reg == '0))
        else $error("accepted press did not restart cooldown");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for moisture_pump_controller: directed ticks,
// timer limit cases and random traffic checked against an in-line controller
// prediction. Depends on mpc_pkg and the moisture_pump_controller RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpc_pkg::*;

    // Give up well past the slowest legal run.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TICK_W = TIMER_BITS_DEF;

    // One result word as the block should present it.
    typedef struct packed {
        logic               pump;
        logic [1:0]         ctrl;
        logic [MOIST_W-1:0] level;
        logic               press_ok;
    } status_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  sample_valid;
    logic [MOIST_W-1:0]    moisture;
    logic                  button_press;
    logic                  out_valid;
    logic                  out_stall;
    logic                  pump_on;
    logic [1:0]            mode;
    logic [MOIST_W-1:0]    last_moisture;
    logic                  press_accepted;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted controller: its own copy of the registers and the state.
    logic [MOIST_W-1:0] dry_level;
    logic [MOIST_W-1:0] wet_level;
    logic [LIMIT_W-1:0] water_limit;
    logic [LIMIT_W-1:0] soak_limit;
    logic [LIMIT_W-1:0] cooldown_limit;
    logic [1:0]         ctrl_state;
    logic [MOIST_W-1:0] held_level;
    logic [TICK_W-1:0]  phase_count;
    logic [TICK_W-1:0]  press_age_count;

    // Result words still owed by the block, oldest first.
    status_word_t expected_status[$];
    status_word_t oldest_status;

    int mismatch_count = 0;
    int cycle_count = 0;
    // Idle and stall odds, in percent per cycle, for the current phase.
    int gap_pct = 0;
    int stall_pct = 0;
    // Length of a receiver hold-off; picked up and cleared by the receiver.
    int hold_request = 0;

    moisture_pump_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_valid   (sample_valid),
        .moisture       (moisture),
        .button_press   (button_press),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pump_on        (pump_on),
        .mode           (mode),
        .last_moisture  (last_moisture),
        .press_accepted (press_accepted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Advance the predicted controller by one tick and return the result
    // word it owes. Order inside a tick: age both timers, take the press,
    // take the sample, then evaluate the state once.
    function automatic status_word_t advance_controller(logic fresh, logic [MOIST_W-1:0] level,
                                                        logic pressed);
        status_word_t r;
        logic took;
        took = 1'b0;
        if (press_age_count != '1)
            press_age_count++;
        if ((ctrl_state == MODE_WATER || ctrl_state == MODE_SOAK) && phase_count != '1)
            phase_count++;
        if (pressed && press_age_count >= cooldown_limit)
        begin
            took = 1'b1;
            press_age_count = '0;
            if (ctrl_state == MODE_IDLE)
            begin
                ctrl_state = MODE_WATER;
                phase_count = '0;
            end
        end
        if (fresh)
            held_level = level;
        case (ctrl_state)
            MODE_IDLE:
            begin
                if (held_level < dry_level)
                begin
                    ctrl_state = MODE_WATER;
                    phase_count = '0;
                end
            end
            MODE_WATER:
            begin
                // Wet soil or the time limit ends watering; both lead to soaking.
                if (held_level >= wet_level || phase_count >= water_limit)
                begin
                    ctrl_state = MODE_SOAK;
                    phase_count = '0;
                end
            end
            MODE_SOAK:
            begin
                if (phase_count >= soak_limit)
                    ctrl_state = MODE_IDLE;
            end
            default:
                ctrl_state = MODE_IDLE;
        endcase
        r.pump = (ctrl_state == MODE_WATER);
        r.ctrl = ctrl_state;
        r.level = held_level;
        r.press_ok = took;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Check every result word against the oldest expectation, then predict
    // the tick accepted on the same edge. Both use pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    $error("result word with nothing expected");
                end
                else
                begin
                    oldest_status = expected_status.pop_front();
                    if (pump_on !== oldest_status.pump)
                        report_mismatch("pump_on", oldest_status.pump, pump_on);
                    if (mode !== oldest_status.ctrl)
                        report_mismatch("mode", oldest_status.ctrl, mode);
                    if (last_moisture !== oldest_status.level)
                        report_mismatch("last_moisture", oldest_status.level, last_moisture);
                    if (press_accepted !== oldest_status.press_ok)
                        report_mismatch("press_accepted", oldest_status.press_ok,
                                        press_accepted);
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                expected_status.push_back(advance_controller(sample_valid, moisture,
                                                             button_press));
        end
    end

    // Receiver: stall at random per phase, or hold off for a requested
    // stretch so the block fills up and pushes back on its input.
    initial
    begin
        int hold_len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_len = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (hold_len) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one tick word; drop valid during random gaps, hold the payload
    // until the block takes it. Valid stays high for a back-to-back word.
    task automatic send_tick(input logic fresh, input logic [MOIST_W-1:0] level,
                             input logic pressed);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample_valid <= fresh;
        moisture <= level;
        button_press <= pressed;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Stop offering ticks and wait until every owed word has come back,
    // plus the block's latency, so registers may be written safely.
    task automatic wait_idle;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register and mirror it, keeping only the register's width.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_DRY:      dry_level = value[MOIST_W-1:0];
            REG_WET:      wet_level = value[MOIST_W-1:0];
            REG_WATER:    water_limit = value[LIMIT_W-1:0];
            REG_SOAK:     soak_limit = value[LIMIT_W-1:0];
            REG_COOLDOWN: cooldown_limit = value[LIMIT_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [MOIST_W-1:0] dry, input logic [MOIST_W-1:0] wet,
                                  input logic [LIMIT_W-1:0] water,
                                  input logic [LIMIT_W-1:0] soak,
                                  input logic [LIMIT_W-1:0] cool);
        write_setting(REG_DRY, CFG_DATA_W'(dry));
        write_setting(REG_WET, CFG_DATA_W'(wet));
        write_setting(REG_WATER, water);
        write_setting(REG_SOAK, soak);
        write_setting(REG_COOLDOWN, cool);
    endtask

    // Short timers and cooldowns keep the controller cycling through all
    // three states many times per phase.
    task automatic pick_random_settings;
        logic [MOIST_W-1:0] dry;
        dry = MOIST_W'($urandom_range(120, 20));
        apply_settings(dry, MOIST_W'($urandom_range(255, 0)), LIMIT_W'($urandom_range(40, 0)),
                       LIMIT_W'($urandom_range(40, 0)), LIMIT_W'($urandom_range(30, 0)));
    endtask

    // Moisture a step or two around a threshold, clipped to the field range.
    function automatic logic [MOIST_W-1:0] near_level(logic [MOIST_W-1:0] lvl);
        int v;
        v = int'(lvl) + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return MOIST_W'(v);
    endfunction

    // Random ticks: mostly moisture near the live thresholds so every
    // transition fires often, with extremes and fully random values mixed in.
    task automatic run_random_ticks(input int count);
        logic fresh;
        logic pressed;
        logic [MOIST_W-1:0] level;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            fresh = ($urandom_range(1) == 1);
            pressed = ($urandom_range(99) < 20);
            if (pick < 15)
                level = ($urandom_range(1) == 1) ? '1 : '0;
            else if (pick < 55)
                level = near_level(dry_level);
            else if (pick < 80)
                level = near_level(wet_level);
            else
                level = MOIST_W'($urandom_range(255));
            send_tick(fresh, level, pressed);
        end
    endtask

    // Reset values: held moisture 50, thresholds 30 and 60, cooldown running.
    task automatic test_reset_values;
        send_tick(1'b0, 8'hFF, 1'b0);  // sample ignored without its flag
        send_tick(1'b0, 8'h00, 1'b1);  // press inside the reset cooldown
        send_tick(1'b1, 8'd30, 1'b0);  // at the dry threshold: stay idle
        send_tick(1'b1, 8'd29, 1'b0);  // below it: start watering
        send_tick(1'b1, 8'd59, 1'b0);
        send_tick(1'b1, 8'd60, 1'b1);  // at the wet threshold: soak
        send_tick(1'b1, 8'd0, 1'b0);   // dry soil does nothing while soaking
    endtask

    // Default timers: press on every tick while the reset cooldown still
    // runs, so every press is refused and soaking carries on.
    task automatic test_default_timers;
        for (int k = 0; k < 60; k++)
            send_tick(1'b0, MOIST_W'($urandom_range(255)), 1'b1);
    endtask

    task automatic test_press_and_thresholds;
        wait_idle;
        // Zero timers settle any state back to idle within two ticks.
        apply_settings(8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
        send_tick(1'b1, 8'h80, 1'b0);
        send_tick(1'b0, 8'h00, 1'b0);
        send_tick(1'b1, 8'd0, 1'b1);    // forced watering ends at once on a zero limit
        wait_idle;
        write_setting(REG_WATER, 16'd4);
        write_setting(REG_SOAK, 16'd1);
        send_tick(1'b0, 8'd0, 1'b0);
        send_tick(1'b1, 8'd100, 1'b1);  // press forces watering from idle
        send_tick(1'b0, 8'd0, 1'b1);    // press while watering: taken, no effect
        send_tick(1'b1, 8'd255, 1'b1);
        send_tick(1'b0, 8'd0, 1'b1);    // press while soaking: taken, no effect
        send_tick(1'b1, 8'd255, 1'b1);  // forced watering ends at once on wet soil
        send_tick(1'b1, 8'd0, 1'b0);
        wait_idle;
        write_setting(REG_DRY, 16'd255);
        send_tick(1'b1, 8'd254, 1'b0);
        send_tick(1'b1, 8'd255, 1'b0);
    endtask

    // Writes past the last register must be dropped; wide data keeps only
    // the low bits of each register.
    task automatic test_register_decode;
        wait_idle;
        for (int idx = REG_COOLDOWN + 1; idx < (1 << CFG_IDX_W); idx++)
            write_setting(CFG_IDX_W'(idx), CFG_DATA_W'($urandom_range(16'hFFFF)));
        write_setting(REG_DRY, 16'hA528);
        write_setting(REG_WET, 16'h5A29);
        send_tick(1'b1, 8'd39, 1'b0);
        send_tick(1'b1, 8'd41, 1'b0);
        send_tick(1'b1, 8'd40, 1'b1);
    endtask

    // Longest limits: soak holds with its limit at the top of the range and
    // the longest cooldown refuses every press.
    task automatic test_timer_saturation;
        wait_idle;
        apply_settings(8'd255, 8'd255, 16'd0, 16'd0, 16'hFFFF);
        send_tick(1'b1, 8'd255, 1'b0);
        send_tick(1'b1, 8'd255, 1'b0);
        wait_idle;
        write_setting(REG_SOAK, 16'hFFFF);
        send_tick(1'b1, 8'd0, 1'b0);
        send_tick(1'b1, 8'd255, 1'b0);
        for (int k = 0; k < 40; k++)
            send_tick(1'b0, MOIST_W'($urandom_range(255)), 1'b0);
        for (int k = 0; k < 3; k++)
            send_tick(1'b0, 8'd0, 1'b1);
    endtask

    // Random traffic over four idling phases, two settings each.
    task automatic test_random_traffic;
        wait_idle;
        gap_pct = 0;
        stall_pct = 0;
        apply_settings(8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
        run_random_ticks(210);
        wait_idle;
        pick_random_settings;
        run_random_ticks(210);

        gap_pct = 74;
        wait_idle;
        pick_random_settings;
        run_random_ticks(210);
        wait_idle;
        apply_settings(8'd255, 8'd255, 16'hFFFF, 16'd0, 16'd1);
        run_random_ticks(210);

        gap_pct = 0;
        stall_pct = 74;
        wait_idle;
        pick_random_settings;
        run_random_ticks(210);
        wait_idle;
        pick_random_settings;
        run_random_ticks(210);

        gap_pct = 35;
        stall_pct = 35;
        wait_idle;
        apply_settings(8'd128, 8'd0, 16'd1, 16'd3, 16'hFFFF);
        run_random_ticks(210);
        wait_idle;
        pick_random_settings;
        run_random_ticks(210);
    endtask

    // Hold the receiver off for a long stretch while ticks keep coming.
    task automatic test_backpressure;
        wait_idle;
        gap_pct = 0;
        stall_pct = 20;
        pick_random_settings;
        hold_request = 300;
        run_random_ticks(60);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_valid = 1'b0;
        moisture = '0;
        button_press = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DRY;
        cfg_data = '0;

        // Mirror the reset state of the block.
        dry_level = DRY_RESET;
        wet_level = WET_RESET;
        water_limit = WATER_RESET;
        soak_limit = SOAK_RESET;
        cooldown_limit = COOLDOWN_RESET;
        ctrl_state = MODE_IDLE;
        held_level = MOIST_RESET;
        phase_count = '0;
        press_age_count = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values;
        test_default_timers;
        test_press_and_thresholds;
        test_register_decode;
        test_timer_saturation;
        test_random_traffic;
        test_backpressure;
        wait_idle;

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/mpc_pkg.sv
rtl/moisture_pump_controller.sv
tb/testbench.sv
